/* src/phjs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// phjs_pkg
// Shared types and constants of the plate heat Jacobi solver: transaction
// payloads, controller command and datapath status bundles.
// ----------------------------------------------------------------------------
package phjs_pkg;

	localparam int TEMP_W  = 24;
	localparam int TOL_W   = 23;
	localparam int IDX_W   = 3;
	localparam int SWEEP_W = 13;
	localparam int SUM_W   = TEMP_W + 2;

	typedef struct packed {
		logic signed [TEMP_W-1:0] top_temp;
		logic signed [TEMP_W-1:0] bottom_temp;
		logic signed [TEMP_W-1:0] left_temp;
		logic signed [TEMP_W-1:0] right_temp;
		logic        [TOL_W-1:0]  tolerance;
	} job_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0]  cell_temp;
		logic        [IDX_W-1:0]   row_index;
		logic        [IDX_W-1:0]   col_index;
		logic                      last;
		logic                      converged;
		logic        [SWEEP_W-1:0] sweep_count;
	} cell_t;

	typedef struct packed {
		logic               load_job;
		logic               mem_we;
		logic               wr_edge;
		logic               wr_bank;
		logic [IDX_W-1:0]   wr_row;
		logic [IDX_W-1:0]   wr_col;
		logic               rd_bank;
		logic [IDX_W-1:0]   rd_row;
		logic [IDX_W-1:0]   rd_col;
		logic               sum_load;
		logic               sum_add;
		logic               calc_diff;
		logic               upd_max;
		logic               max_clr;
		logic               load_out;
		logic               out_last;
		logic               out_conv;
		logic [SWEEP_W-1:0] out_sweeps;
	} cmd_t;

	typedef struct packed {
		logic max_le_tol;
	} status_t;

endpackage
`default_nettype wire

/* src/phjs_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// phjs_datapath
// Plate memory (two banks, ping-pong per sweep), neighbor sum accumulator,
// change tracking and the output register.
// ----------------------------------------------------------------------------
module phjs_datapath #(
	parameter int ROWS = 6,
	parameter int COLS = 8
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  phjs_pkg::cmd_t        cmd,
	input  phjs_pkg::job_t        job,
	output phjs_pkg::status_t     status,
	output phjs_pkg::cell_t       plate_cell
);

	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLS);
	localparam int AW    = 1 + RW + CW;
	localparam int DEPTH = 1 << AW;
	localparam int TW    = phjs_pkg::TEMP_W;
	localparam int SW    = phjs_pkg::SUM_W;

	logic signed [TW-1:0]           mem [DEPTH];
	logic signed [TW-1:0]           rdata_q;
	logic signed [TW-1:0]           top_q, bot_q, lft_q, rgt_q;
	logic [phjs_pkg::TOL_W-1:0]     tol_q;
	logic signed [SW-1:0]           sum_q;
	logic signed [TW-1:0]           v_q;
	logic signed [TW:0]             d_q;
	logic [TW-1:0]                  max_q;
	logic signed [TW-1:0]           edge_val;
	logic signed [TW-1:0]           wdata;
	logic signed [TW-1:0]           mean;
	logic signed [SW-1:0]           rdata_ext;
	logic signed [TW:0]             abs_d;
	logic [AW-1:0]                  waddr, raddr;

	// bottom row wins its corners, left/right win the top corners
	always_comb begin
		if (cmd.wr_row == phjs_pkg::IDX_W'(ROWS - 1))
			edge_val = bot_q;
		else if (cmd.wr_col == '0)
			edge_val = lft_q;
		else if (cmd.wr_col == phjs_pkg::IDX_W'(COLS - 1))
			edge_val = rgt_q;
		else if (cmd.wr_row == '0)
			edge_val = top_q;
		else
			edge_val = '0;
	end

	assign wdata     = cmd.wr_edge ? edge_val : v_q;
	assign waddr     = {cmd.wr_bank, cmd.wr_row[RW-1:0], cmd.wr_col[CW-1:0]};
	assign raddr     = {cmd.rd_bank, cmd.rd_row[RW-1:0], cmd.rd_col[CW-1:0]};
	assign rdata_ext = {{(SW - TW){rdata_q[TW-1]}}, rdata_q};
	// floor divide by 4
	assign mean      = sum_q[SW-1:2];
	assign abs_d     = d_q[TW] ? -d_q : d_q;

	always_ff @(posedge clk) begin
		if (cmd.mem_we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_job) begin
			top_q <= job.top_temp;
			bot_q <= job.bottom_temp;
			lft_q <= job.left_temp;
			rgt_q <= job.right_temp;
			tol_q <= job.tolerance;
		end
		if (cmd.sum_load)
			sum_q <= rdata_ext;
		else if (cmd.sum_add)
			sum_q <= sum_q + rdata_ext;
		if (cmd.calc_diff) begin
			v_q <= mean;
			d_q <= {mean[TW-1], mean} - {rdata_q[TW-1], rdata_q};
		end
		if (cmd.load_out) begin
			plate_cell.cell_temp   <= rdata_q;
			plate_cell.row_index   <= cmd.rd_row;
			plate_cell.col_index   <= cmd.rd_col;
			plate_cell.last        <= cmd.out_last;
			plate_cell.converged   <= cmd.out_conv;
			plate_cell.sweep_count <= cmd.out_sweeps;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= '0;
		end else if (cmd.max_clr) begin
			max_q <= '0;
		end else if (cmd.upd_max && (abs_d[TW-1:0] > max_q)) begin
			max_q <= abs_d[TW-1:0];
		end
	end

	assign status.max_le_tol = (max_q <= {1'b0, tol_q});

endmodule
`default_nettype wire

/* src/phjs_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// phjs_ctrl
// Sequencer of the solver: edge build over both banks, per-cell neighbor
// reads and write-back, convergence check and row-major readout.
// ----------------------------------------------------------------------------
module phjs_ctrl #(
	parameter int ROWS       = 6,
	parameter int COLS       = 8,
	parameter int MAX_SWEEPS = 4096
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                job_valid,
	output logic               job_stall,
	output logic               cell_valid,
	input  wire                cell_stall,
	input  phjs_pkg::status_t  status,
	output phjs_pkg::cmd_t     cmd
);

	localparam int IW = phjs_pkg::IDX_W;
	localparam int SW = phjs_pkg::SWEEP_W;

	localparam logic [IW-1:0] R_LAST = IW'(ROWS - 1);
	localparam logic [IW-1:0] C_LAST = IW'(COLS - 1);
	localparam logic [IW-1:0] R_INT  = IW'(ROWS - 2);
	localparam logic [IW-1:0] C_INT  = IW'(COLS - 2);
	localparam logic [SW-1:0] SW_CAP = SW'(MAX_SWEEPS);

	localparam logic [2:0] PH_UP     = 3'd0;
	localparam logic [2:0] PH_LEFT   = 3'd1;
	localparam logic [2:0] PH_DOWN   = 3'd2;
	localparam logic [2:0] PH_RIGHT  = 3'd3;
	localparam logic [2:0] PH_CENTER = 3'd4;
	localparam logic [2:0] PH_CALC   = 3'd5;
	localparam logic [2:0] PH_WRITE  = 3'd6;
	localparam logic [2:0] PH_EM_RD  = 3'd0;
	localparam logic [2:0] PH_EM_LD  = 3'd1;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_BUILD = 5'b00010,
		S_SWEEP = 5'b00100,
		S_CHECK = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	state_t        state_q, state_d;
	logic [IW-1:0] row_q, row_d, col_q, col_d;
	logic [2:0]    ph_q, ph_d;
	logic          bank_q, bank_d, bsel_q, bsel_d, conv_q, conv_d;
	logic [SW-1:0] sweep_q, sweep_d, sweep_n;
	logic          out_valid_q;
	logic          slot_free;

	assign job_stall  = (state_q != S_IDLE);
	assign cell_valid = out_valid_q;
	assign slot_free  = !out_valid_q || !cell_stall;
	assign sweep_n    = sweep_q + SW'(1);

	always_comb begin
		cmd         = '0;
		cmd.rd_bank = bank_q;
		cmd.rd_row  = row_q;
		cmd.rd_col  = col_q;
		cmd.wr_row  = row_q;
		cmd.wr_col  = col_q;
		state_d     = state_q;
		row_d       = row_q;
		col_d       = col_q;
		ph_d        = ph_q;
		bank_d      = bank_q;
		bsel_d      = bsel_q;
		conv_d      = conv_q;
		sweep_d     = sweep_q;
		case (state_q)
			S_IDLE: begin
				if (job_valid) begin
					cmd.load_job = 1'b1;
					state_d      = S_BUILD;
					row_d        = '0;
					col_d        = '0;
					bsel_d       = 1'b0;
				end
			end
			S_BUILD: begin
				cmd.mem_we  = 1'b1;
				cmd.wr_edge = 1'b1;
				cmd.wr_bank = bsel_q;
				if (col_q == C_LAST) begin
					col_d = '0;
					if (row_q == R_LAST) begin
						row_d = '0;
						if (bsel_q) begin
							state_d     = S_SWEEP;
							row_d       = IW'(1);
							col_d       = IW'(1);
							ph_d        = PH_UP;
							bank_d      = 1'b0;
							sweep_d     = '0;
							cmd.max_clr = 1'b1;
						end else begin
							bsel_d = 1'b1;
						end
					end else begin
						row_d = row_q + IW'(1);
					end
				end else begin
					col_d = col_q + IW'(1);
				end
			end
			S_SWEEP: begin
				ph_d = ph_q + 3'd1;
				case (ph_q)
					PH_UP: cmd.rd_row = row_q - IW'(1);
					PH_LEFT: begin
						cmd.rd_col   = col_q - IW'(1);
						cmd.sum_load = 1'b1;
					end
					PH_DOWN: begin
						cmd.rd_row  = row_q + IW'(1);
						cmd.sum_add = 1'b1;
					end
					PH_RIGHT: begin
						cmd.rd_col  = col_q + IW'(1);
						cmd.sum_add = 1'b1;
					end
					PH_CENTER: cmd.sum_add = 1'b1;
					PH_CALC: cmd.calc_diff = 1'b1;
					PH_WRITE: begin
						cmd.upd_max = 1'b1;
						cmd.mem_we  = 1'b1;
						cmd.wr_bank = ~bank_q;
						ph_d        = PH_UP;
						if (col_q == C_INT) begin
							col_d = IW'(1);
							if (row_q == R_INT)
								state_d = S_CHECK;
							else
								row_d = row_q + IW'(1);
						end else begin
							col_d = col_q + IW'(1);
						end
					end
					default: ph_d = PH_UP;
				endcase
			end
			S_CHECK: begin
				// fresh values sit in the other bank from here on
				sweep_d = sweep_n;
				conv_d  = status.max_le_tol;
				bank_d  = ~bank_q;
				row_d   = IW'(1);
				col_d   = IW'(1);
				ph_d    = PH_UP;
				if (status.max_le_tol || (sweep_n >= SW_CAP)) begin
					state_d = S_EMIT;
					row_d   = '0;
					col_d   = '0;
					ph_d    = PH_EM_RD;
				end else begin
					state_d     = S_SWEEP;
					cmd.max_clr = 1'b1;
				end
			end
			S_EMIT: begin
				cmd.out_last   = (row_q == R_LAST) && (col_q == C_LAST);
				cmd.out_conv   = conv_q;
				cmd.out_sweeps = sweep_q;
				if (ph_q == PH_EM_RD) begin
					ph_d = PH_EM_LD;
				end else if (slot_free) begin
					cmd.load_out = 1'b1;
					ph_d         = PH_EM_RD;
					if (col_q == C_LAST) begin
						col_d = '0;
						if (row_q == R_LAST)
							state_d = S_IDLE;
						else
							row_d = row_q + IW'(1);
					end else begin
						col_d = col_q + IW'(1);
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_q       <= '0;
			col_q       <= '0;
			ph_q        <= PH_UP;
			bank_q      <= 1'b0;
			bsel_q      <= 1'b0;
			conv_q      <= 1'b0;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			row_q   <= row_d;
			col_q   <= col_d;
			ph_q    <= ph_d;
			bank_q  <= bank_d;
			bsel_q  <= bsel_d;
			conv_q  <= conv_d;
			sweep_q <= sweep_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (!cell_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

/* src/plate_heat_jacobi_solver_core.sv */
// Sequence: edge build over both banks, then the sweeps (one memory read port,
// five reads per interior cell), then the readout of every cell.
// Throughput: one job at a time; a new job is taken once the last cell of the
// previous job sits in the output register.
// Reset: arst_n clears the controller and the output valid; memory is not cleared.
`default_nettype none
// ----------------------------------------------------------------------------
// plate_heat_jacobi_solver_core
// Jacobi heat solver on a small plate: builds the edges, sweeps until the
// largest change meets the tolerance or the sweep cap, then streams all cells.
// ----------------------------------------------------------------------------
module plate_heat_jacobi_solver_core #(
	parameter int ROWS       = 6,
	parameter int COLS       = 8,
	parameter int MAX_SWEEPS = 4096
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              job_valid,
	output logic             job_stall,
	input  phjs_pkg::job_t   job,
	output logic             cell_valid,
	input  wire              cell_stall,
	output phjs_pkg::cell_t  plate_cell
);

	phjs_pkg::cmd_t    cmd;
	phjs_pkg::status_t status;

	phjs_ctrl #(
		.ROWS       (ROWS),
		.COLS       (COLS),
		.MAX_SWEEPS (MAX_SWEEPS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (job_valid),
		.job_stall  (job_stall),
		.cell_valid (cell_valid),
		.cell_stall (cell_stall),
		.status     (status),
		.cmd        (cmd)
	);

	phjs_datapath #(
		.ROWS (ROWS),
		.COLS (COLS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.job        (job),
		.status     (status),
		.plate_cell (plate_cell)
	);

endmodule
`default_nettype wire

/* src/phjs_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// phjs_checker
// Port-level checks of the solver's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module phjs_checker #(
	parameter int ROWS       = 6,
	parameter int COLS       = 8,
	parameter int MAX_SWEEPS = 4096
) (
	input wire             clk,
	input wire             arst_n,
	input wire             cell_valid,
	input wire             cell_stall,
	input phjs_pkg::cell_t plate_cell
);

	localparam logic [phjs_pkg::IDX_W-1:0]   R_LAST = phjs_pkg::IDX_W'(ROWS - 1);
	localparam logic [phjs_pkg::IDX_W-1:0]   C_LAST = phjs_pkg::IDX_W'(COLS - 1);
	localparam logic [phjs_pkg::SWEEP_W-1:0] SW_CAP = phjs_pkg::SWEEP_W'(MAX_SWEEPS);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid && cell_stall |=> cell_valid && $stable(plate_cell))
		else $error("stalled result transaction changed");

	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid |-> (plate_cell.row_index <= R_LAST) &&
			(plate_cell.col_index <= C_LAST))
		else $error("cell index outside the plate");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid |-> plate_cell.last ==
			((plate_cell.row_index == R_LAST) && (plate_cell.col_index == C_LAST)))
		else $error("last flag not on the final cell");

	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid |-> (plate_cell.sweep_count != '0) && (plate_cell.sweep_count <= SW_CAP) &&
			(plate_cell.converged || (plate_cell.sweep_count == SW_CAP)))
		else $error("sweep count or converged flag inconsistent");

endmodule

bind plate_heat_jacobi_solver_core phjs_checker #(
	.ROWS       (ROWS),
	.COLS       (COLS),
	.MAX_SWEEPS (MAX_SWEEPS)
) u_phjs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cell_valid (cell_valid),
	.cell_stall (cell_stall),
	.plate_cell (plate_cell)
);
`default_nettype wire

/* dv/plate_heat_jacobi_solver_core_test.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plate_heat_jacobi_solver_core_test
// Self-checking bench for the Jacobi plate solver. Every accepted job is
// solved by a behavioral plate model. The 48 expected cells go into a queue,
// and each emitted cell is compared against it field by field. Directed jobs
// cover the edge build, temperature extremes, floor rounding, tolerance
// limits and the sweep cap. Random jobs follow under four handshake pacing
// phases.
// ----------------------------------------------------------------------------
module plate_heat_jacobi_solver_core_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROWS        = 6;
	localparam int COLS        = 8;
	localparam int CELLS       = ROWS * COLS;
	localparam int MAX_SWEEPS  = 4096;
	localparam int CLK_PERIOD  = 12;
	localparam int RAND_SWEEPS = 80;
	localparam int DRAIN_CYCLES = 400;
	localparam int TIMEOUT_CYCLES = 100_000_000;

	typedef logic signed [phjs_pkg::TEMP_W-1:0] temp_t;

	localparam temp_t TEMP_MAX = 24'sh7FFFFF;
	localparam temp_t TEMP_MIN = 24'sh800000;
	localparam logic [phjs_pkg::TOL_W-1:0] TOL_MAX = 23'h7FFFFF;

	logic            clk;
	logic            arst_n     = 1'b0;
	logic            job_valid  = 1'b0;
	logic            job_stall;
	phjs_pkg::job_t  job        = '0;
	logic            cell_valid;
	logic            cell_stall = 1'b0;
	phjs_pkg::cell_t plate_cell;

	phjs_pkg::cell_t expected_cells[$];
	temp_t solved_plate[CELLS];
	int    job_idle_pct   = 0;
	int    cell_stall_pct = 0;
	int    failures       = 0;
	int    jobs_sent      = 0;
	int    capped_jobs    = 0;
	int    cells_checked  = 0;

	plate_heat_jacobi_solver_core #(
		.ROWS       (ROWS),
		.COLS       (COLS),
		.MAX_SWEEPS (MAX_SWEEPS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (job_valid),
		.job_stall  (job_stall),
		.job        (job),
		.cell_valid (cell_valid),
		.cell_stall (cell_stall),
		.plate_cell (plate_cell)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("** plate_heat_jacobi_solver_core: FAILED **");
		$finish;
	end

	// Build the edges, sweep to tolerance or cap, leave the plate in solved_plate.
	function automatic void solve_plate(input phjs_pkg::job_t j, output int sweeps,
			output bit conv);
		int cur[CELLS];
		int nxt[CELLS];
		int r, c, idx, sum, v, d, biggest;
		for (idx = 0; idx < CELLS; idx++)
			cur[idx] = 0;
		for (c = 0; c < COLS; c++) begin
			cur[c] = int'($signed(j.top_temp));
			cur[(ROWS - 1) * COLS + c] = int'($signed(j.bottom_temp));
		end
		for (r = 0; r < ROWS - 1; r++) begin
			cur[r * COLS] = int'($signed(j.left_temp));
			cur[r * COLS + COLS - 1] = int'($signed(j.right_temp));
		end
		sweeps = 0;
		do begin
			biggest = 0;
			for (r = 1; r < ROWS - 1; r++) begin
				for (c = 1; c < COLS - 1; c++) begin
					idx = r * COLS + c;
					sum = cur[idx - COLS] + cur[idx - 1] + cur[idx + COLS] + cur[idx + 1];
					v = sum >>> 2;
					d = v - cur[idx];
					if (d < 0)
						d = -d;
					if (d > biggest)
						biggest = d;
					nxt[idx] = v;
				end
			end
			for (r = 1; r < ROWS - 1; r++)
				for (c = 1; c < COLS - 1; c++)
					cur[r * COLS + c] = nxt[r * COLS + c];
			sweeps++;
			conv = (biggest <= int'(j.tolerance));
		end while (!conv && sweeps < MAX_SWEEPS);
		for (idx = 0; idx < CELLS; idx++)
			solved_plate[idx] = temp_t'(cur[idx]);
	endfunction

	function automatic phjs_pkg::job_t make_job(input temp_t top, input temp_t bottom,
			input temp_t left, input temp_t right, input logic [phjs_pkg::TOL_W-1:0] tol);
		phjs_pkg::job_t j;
		j.top_temp    = top;
		j.bottom_temp = bottom;
		j.left_temp   = left;
		j.right_temp  = right;
		j.tolerance   = tol;
		return j;
	endfunction

	function automatic temp_t rand_temp();
		temp_t t;
		t = temp_t'($urandom);
		if ($urandom_range(0, 3) != 0)
			t = t >>> $urandom_range(0, phjs_pkg::TEMP_W - 1);
		return t;
	endfunction

	function automatic phjs_pkg::job_t rand_job();
		return make_job(rand_temp(), rand_temp(), rand_temp(), rand_temp(),
			phjs_pkg::TOL_W'($urandom) >> $urandom_range(0, 14));
	endfunction

	// Entered and left at a falling edge; valid stays high into the next call.
	task automatic send_job(input phjs_pkg::job_t j);
		int sweeps, idx;
		bit conv;
		phjs_pkg::cell_t want;
		while ($urandom_range(1, 100) <= job_idle_pct) begin
			job_valid <= 1'b0;
			@(negedge clk);
		end
		job       <= j;
		job_valid <= 1'b1;
		do @(posedge clk); while (job_stall);
		solve_plate(j, sweeps, conv);
		for (idx = 0; idx < CELLS; idx++) begin
			want.cell_temp   = solved_plate[idx];
			want.row_index   = phjs_pkg::IDX_W'(idx / COLS);
			want.col_index   = phjs_pkg::IDX_W'(idx % COLS);
			want.last        = (idx == CELLS - 1);
			want.converged   = conv;
			want.sweep_count = phjs_pkg::SWEEP_W'(sweeps);
			expected_cells.push_back(want);
		end
		jobs_sent++;
		if (!conv)
			capped_jobs++;
		@(negedge clk);
	endtask

	task automatic test_edge_build();
		send_job(make_job(24'sh000100, -24'sh000200, 24'sh000300, -24'sh000400, 23'h40));
		send_job(make_job(24'sh123456, 24'shABCDEF, 24'sh5A5A5A, 24'shA5A5A5, 23'h1234));
		send_job(make_job(24'sh555555, 24'shAAAAAA, 24'sh2AAAAA, 24'shD55555, 23'h2AAAAA));
	endtask

	task automatic test_extremes();
		send_job(make_job('0, '0, '0, '0, '0));
		send_job(make_job(TEMP_MAX, TEMP_MAX, TEMP_MAX, TEMP_MAX, '0));
		send_job(make_job(TEMP_MIN, TEMP_MIN, TEMP_MIN, TEMP_MIN, '0));
		send_job(make_job(TEMP_MAX, TEMP_MIN, TEMP_MIN, TEMP_MIN, 23'h100));
		send_job(make_job(TEMP_MIN, TEMP_MAX, TEMP_MAX, TEMP_MIN, 23'h100));
		send_job(make_job(TEMP_MAX, TEMP_MIN, TEMP_MAX, TEMP_MIN, TOL_MAX));
	endtask

	// Floor of negative quarter-sums must round toward minus infinity.
	task automatic test_rounding();
		send_job(make_job(-24'sd1, -24'sd1, -24'sd1, -24'sd1, '0));
		send_job(make_job(24'sd1, 24'sd1, 24'sd1, 24'sd1, '0));
		send_job(make_job(-24'sd3, '0, '0, '0, '0));
		send_job(make_job(24'sd3, '0, -24'sd1, '0, 23'd1));
		send_job(make_job(24'sd2, -24'sd5, 24'sd7, -24'sd1, 23'd2));
	endtask

	task automatic test_tolerance_limits();
		send_job(make_job(24'sh010000, -24'sh020000, 24'sh004000, 24'sh000080, TOL_MAX));
		send_job(make_job(24'sh000800, 24'sh000400, 24'sh000200, 24'sh000100, 23'd0));
		send_job(make_job(24'sh400000, -24'sh400000, 24'sh200000, -24'sh200000, 23'h000100));
	endtask

	// Hunt for a job whose floored sweeps never settle, so the cap ends it.
	task automatic test_sweep_cap();
		phjs_pkg::job_t j;
		int tries, sweeps;
		bit conv;
		for (tries = 0; tries < 48; tries++) begin
			j = make_job(temp_t'($urandom), temp_t'($urandom), temp_t'($urandom),
				temp_t'($urandom), '0);
			solve_plate(j, sweeps, conv);
			if (!conv)
				break;
		end
		send_job(j);
	endtask

	task automatic test_random_jobs(input int count, input int idle_pct, input int stall_pct);
		phjs_pkg::job_t j;
		int n, sweeps;
		bit conv;
		job_idle_pct   = idle_pct;
		cell_stall_pct = stall_pct;
		for (n = 0; n < count; n++) begin
			// Redraw jobs that would sweep for long; keeps the run short.
			do begin
				j = rand_job();
				solve_plate(j, sweeps, conv);
			end while (sweeps > RAND_SWEEPS);
			send_job(j);
		end
	endtask

	always @(negedge clk)
		cell_stall <= ($urandom_range(1, 100) <= cell_stall_pct);

	function automatic void check_field(input string name, input longint want_v,
			input longint got_v);
		if (want_v != got_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
			failures++;
		end
	endfunction

	always @(posedge clk) begin : check_cells
		phjs_pkg::cell_t want;
		if (arst_n && cell_valid && !cell_stall) begin
			if (expected_cells.size() == 0) begin
				$error("unexpected cell transaction: row %0d col %0d", plate_cell.row_index,
					plate_cell.col_index);
				failures++;
			end else begin
				want = expected_cells.pop_front();
				check_field("cell_temp", longint'(want.cell_temp),
					longint'(plate_cell.cell_temp));
				check_field("row_index", longint'(want.row_index),
					longint'(plate_cell.row_index));
				check_field("col_index", longint'(want.col_index),
					longint'(plate_cell.col_index));
				check_field("last", longint'(want.last), longint'(plate_cell.last));
				check_field("converged", longint'(want.converged),
					longint'(plate_cell.converged));
				check_field("sweep_count", longint'(want.sweep_count),
					longint'(plate_cell.sweep_count));
				cells_checked++;
			end
		end
	end

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_edge_build();
		test_extremes();
		test_rounding();
		test_tolerance_limits();
		test_sweep_cap();
		test_random_jobs(36, 0, 0);
		test_random_jobs(36, 84, 0);
		test_random_jobs(36, 0, 84);
		test_random_jobs(36, 16, 16);
		job_valid <= 1'b0;
		while (expected_cells.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Solved %0d plate jobs (%0d stopped at the sweep cap), %0d cells checked",
			jobs_sent, capped_jobs, cells_checked);
		$display("over directed edge, rounding and tolerance cases and four pacing phases.");
		if (failures == 0)
			$display("** plate_heat_jacobi_solver_core: PASSED **");
		else
			$display("** plate_heat_jacobi_solver_core: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire
